// ===== sv/bmic_pkg.sv =====
// Shared types, operation codes and reset constants for the bank mapper.
// No dependencies; every other file of the block imports this package.
package bmic_pkg;

  // Operation codes carried in the input word.
  localparam logic [1:0] OP_WRITE     = 2'd0;
  localparam logic [1:0] OP_TICK      = 2'd1;
  localparam logic [1:0] OP_CPU_QUERY = 2'd2;
  localparam logic [1:0] OP_PPU_QUERY = 2'd3;

  // Register file geometry.
  localparam int unsigned PROG_DEPTH = 4;
  localparam int unsigned PATT_DEPTH = 8;

  // Address decode, by the top nibble of a CPU address.
  localparam logic [3:0] TOP_PROG_LO = 4'h8;
  localparam logic [3:0] TOP_PROG_HI = 4'h9;
  localparam logic [3:0] TOP_PATT_LO = 4'hA;
  localparam logic [3:0] TOP_PATT_HI = 4'hD;
  localparam logic [3:0] TOP_RELOAD  = 4'hE;
  localparam logic [3:0] TOP_CONTROL = 4'hF;

  // Low address bits of a control write.
  localparam logic [1:0] CTL_ACK_RELOAD = 2'd0;
  localparam logic [1:0] CTL_IRQ_SETUP  = 2'd1;
  localparam logic [1:0] CTL_MIRROR     = 2'd2;

  // Program window that always maps the fixed top bank.
  localparam logic [1:0] PROG_FIXED_WIN = 2'd3;
  localparam logic [7:0] BANK_FIXED     = 8'hFF;

  // Counter masks chosen by the IRQ control bits.
  localparam logic [15:0] MASK_4  = 16'h000F;
  localparam logic [15:0] MASK_8  = 16'h00FF;
  localparam logic [15:0] MASK_12 = 16'h0FFF;
  localparam logic [15:0] MASK_16 = 16'hFFFF;

  localparam logic [7:0] PROG_RESET [PROG_DEPTH] = '{8'h00, 8'h01, 8'hFE, 8'h00};

  typedef struct packed {
    logic [1:0]  operation;
    logic [15:0] address;
    logic [7:0]  data;
  } bmic_in_t;

  typedef struct packed {
    logic [7:0] bank_number;
    logic       bank_valid;
    logic       wram_read_enable;
    logic       wram_write_enable;
    logic [1:0] mirroring_mode;
    logic       irq_line;
  } bmic_out_t;

  // Bank side of one result, handed from the register file to the top level.
  typedef struct packed {
    logic [7:0] bank_number;
    logic       bank_valid;
    logic       wram_rd;
    logic       wram_wr;
    logic [1:0] mirror;
  } bmic_bank_t;

  // Replace the high or the low nibble of a byte with the low nibble of data.
  function automatic logic [7:0] set_nibble(input logic [7:0] old, input logic hi,
                                            input logic [7:0] data);
    logic [7:0] res;
    if (hi) begin
      res = {data[3:0], old[3:0]};
    end else begin
      res = {old[7:4], data[3:0]};
    end
    return res;
  endfunction

endpackage

// ===== sv/bmic_bank_regs.sv =====
// Program, pattern and mirroring registers with their write decode and bank lookup.
// Depends on bmic_pkg.
module bmic_bank_regs (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                step_i,
  input  bmic_pkg::bmic_in_t  item_i,
  output bmic_pkg::bmic_bank_t bank_o
);
  import bmic_pkg::*;

  logic [7:0] prog_q [PROG_DEPTH];
  logic [7:0] prog_d [PROG_DEPTH];
  logic [7:0] patt_q [PATT_DEPTH];
  logic [7:0] patt_d [PATT_DEPTH];
  logic [1:0] mirror_q, mirror_d;

  logic [3:0] top;
  logic [3:0] patt_top;
  logic [1:0] prog_idx;
  logic [2:0] patt_idx;
  logic [1:0] win;

  assign top      = item_i.address[15:12];
  assign patt_top = top - TOP_PATT_LO;
  assign prog_idx = {top[0], item_i.address[1]};
  assign patt_idx = {patt_top[1:0], item_i.address[1]};
  assign win      = item_i.address[14:13];

  always_comb begin
    prog_d   = prog_q;
    patt_d   = patt_q;
    mirror_d = mirror_q;
    if (item_i.operation == OP_WRITE) begin
      if (top inside {[TOP_PROG_LO:TOP_PROG_HI]}) begin
        prog_d[prog_idx] = set_nibble(prog_q[prog_idx], item_i.address[0], item_i.data);
      end else if (top inside {[TOP_PATT_LO:TOP_PATT_HI]}) begin
        patt_d[patt_idx] = set_nibble(patt_q[patt_idx], item_i.address[0], item_i.data);
      end else if (top == TOP_CONTROL && item_i.address[1:0] == CTL_MIRROR) begin
        mirror_d = item_i.data[1:0];
      end
    end
  end

  always_comb begin
    bank_o.bank_number = '0;
    bank_o.bank_valid  = 1'b0;
    case (item_i.operation)
      OP_CPU_QUERY: begin
        if (item_i.address[15]) begin
          bank_o.bank_number = (win == PROG_FIXED_WIN) ? BANK_FIXED : prog_q[win];
          bank_o.bank_valid  = 1'b1;
        end
      end
      OP_PPU_QUERY: begin
        if (item_i.address[15:13] == 3'd0) begin
          bank_o.bank_number = patt_q[item_i.address[12:10]];
          bank_o.bank_valid  = 1'b1;
        end
      end
      default: begin
        bank_o.bank_valid = 1'b0;
      end
    endcase
    // Status reflects the registers as they stand after this word.
    bank_o.wram_rd = prog_d[3][0];
    bank_o.wram_wr = prog_d[3][0] & prog_d[3][1];
    bank_o.mirror  = mirror_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prog_q   <= PROG_RESET;
      patt_q   <= '{default: '0};
      mirror_q <= '0;
    end else if (step_i) begin
      prog_q   <= prog_d;
      patt_q   <= patt_d;
      mirror_q <= mirror_d;
    end
  end

endmodule

// ===== sv/bmic_irq_timer.sv =====
// IRQ reload value, masked down-counter, one-tick delay and interrupt flag.
// Depends on bmic_pkg.
module bmic_irq_timer (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               step_i,
  input  bmic_pkg::bmic_in_t item_i,
  output logic               irq_o
);
  import bmic_pkg::*;

  logic [15:0] reload_q, reload_d;
  logic [15:0] cnt_q, cnt_d;
  logic [3:0]  ctrl_q, ctrl_d;
  logic        delay_q, delay_d;
  logic        flag_q, flag_d;

  logic [3:0]  top;
  logic [15:0] mask;
  logic [15:0] cnt_dec;

  assign top     = item_i.address[15:12];
  assign cnt_dec = cnt_q - 16'd1;

  always_comb begin
    if (ctrl_q[3]) begin
      mask = MASK_4;
    end else if (ctrl_q[2]) begin
      mask = MASK_8;
    end else if (ctrl_q[1]) begin
      mask = MASK_12;
    end else begin
      mask = MASK_16;
    end
  end

  always_comb begin
    reload_d = reload_q;
    cnt_d    = cnt_q;
    ctrl_d   = ctrl_q;
    delay_d  = delay_q;
    flag_d   = flag_q;
    case (item_i.operation)
      OP_WRITE: begin
        if (top == TOP_RELOAD) begin
          case (item_i.address[1:0])
            2'd0:    reload_d[3:0]   = item_i.data[3:0];
            2'd1:    reload_d[7:4]   = item_i.data[3:0];
            2'd2:    reload_d[11:8]  = item_i.data[3:0];
            default: reload_d[15:12] = item_i.data[3:0];
          endcase
        end else if (top == TOP_CONTROL) begin
          if (item_i.address[1:0] == CTL_ACK_RELOAD) begin
            cnt_d  = reload_q;
            flag_d = 1'b0;
          end else if (item_i.address[1:0] == CTL_IRQ_SETUP) begin
            ctrl_d = item_i.data[3:0];
            flag_d = 1'b0;
          end
        end
      end
      OP_TICK: begin
        // A pending delay survives an acknowledge and fires here.
        if (delay_q) begin
          delay_d = 1'b0;
          flag_d  = 1'b1;
        end
        if (ctrl_q[0] && ((cnt_q & mask) != 16'd0)) begin
          cnt_d = cnt_dec;
          if ((cnt_dec & mask) == 16'd0) begin
            delay_d = 1'b1;
          end
        end
      end
      default: begin
        flag_d = flag_q;
      end
    endcase
  end

  assign irq_o = flag_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      reload_q <= '0;
      cnt_q    <= '0;
      ctrl_q   <= '0;
      delay_q  <= 1'b0;
      flag_q   <= 1'b0;
    end else if (step_i) begin
      reload_q <= reload_d;
      cnt_q    <= cnt_d;
      ctrl_q   <= ctrl_d;
      delay_q  <= delay_d;
      flag_q   <= flag_d;
    end
  end

endmodule

// ===== sv/bank_mapper_with_irq_counter.sv =====
// Top level of the cartridge bank mapper with its IRQ counter.
// Depends on bmic_pkg, bmic_bank_regs and bmic_irq_timer.
//
// Usage:
// The input channel (in_valid_i, in_stall_o, in_word_i) takes one word per
// clock while in_stall_o is low: a CPU write, a CPU cycle tick, or a CPU or
// PPU bank query. Every accepted word yields exactly one result word on the
// output channel (out_valid_o, out_stall_i, out_word_o), in order.
// An accepted word sits in the input register, is applied to the mapper
// state as it moves into the result register, or into the skid register
// when the result register is full, and is then offered on the output.
// Throughput is one word per clock while in_stall_o is low; the input
// register feeds a single pass of decode and update logic.
// Results carry the bank for a query plus work RAM enables, mirroring and
// the IRQ line as they stand after the word.
// When the receiver stalls, the result register holds its word and a skid
// register catches one more (up to two results wait). in_stall_o, straight
// from registers, rises only when skid and input registers are both full.
// Reset empties all stages and returns the mapper registers to their
// power-on values; no input is stalled after reset.
module bank_mapper_with_irq_counter (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  bmic_pkg::bmic_in_t  in_word_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output bmic_pkg::bmic_out_t out_word_o
);
  import bmic_pkg::*;

  // Input register.
  bmic_in_t  s1_q;
  logic      s1_valid_q, s1_valid_d;
  // Result register and its skid register.
  bmic_out_t out_q, out_d;
  bmic_out_t skid_q, skid_d;
  logic      out_valid_q, out_valid_d;
  logic      skid_valid_q, skid_valid_d;

  logic       in_accept;
  logic       s1_move;
  logic       pop;
  bmic_bank_t bank;
  logic       irq;
  bmic_out_t  res;

  // The word in the input register moves on whenever the skid slot is free,
  // and only then does it update the mapper state.
  assign s1_move    = s1_valid_q && !skid_valid_q;
  assign in_stall_o = s1_valid_q && skid_valid_q;
  assign in_accept  = in_valid_i && !in_stall_o;
  assign pop        = out_valid_q && !out_stall_i;

  bmic_bank_regs u_bank_regs (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (s1_move),
    .item_i (s1_q),
    .bank_o (bank)
  );

  bmic_irq_timer u_irq_timer (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (s1_move),
    .item_i (s1_q),
    .irq_o  (irq)
  );

  always_comb begin
    res.bank_number       = bank.bank_number;
    res.bank_valid        = bank.bank_valid;
    res.wram_read_enable  = bank.wram_rd;
    res.wram_write_enable = bank.wram_wr;
    res.mirroring_mode    = bank.mirror;
    res.irq_line          = irq;
  end

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (in_accept) begin
      s1_valid_d = 1'b1;
    end else if (s1_move) begin
      s1_valid_d = 1'b0;
    end
  end

  // Two-entry output buffer: the skid word refills the result register on a
  // pop, and a new result lands in whichever slot is free.
  always_comb begin
    out_d        = out_q;
    skid_d       = skid_q;
    out_valid_d  = out_valid_q;
    skid_valid_d = skid_valid_q;
    if (pop) begin
      out_d        = skid_q;
      out_valid_d  = skid_valid_q;
      skid_valid_d = 1'b0;
    end
    if (s1_move) begin
      if (!out_valid_q || pop) begin
        out_d       = res;
        out_valid_d = 1'b1;
      end else begin
        skid_d       = res;
        skid_valid_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q   <= 1'b0;
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      s1_valid_q   <= s1_valid_d;
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_q <= in_word_i;
    end
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

`ifndef ASSERT_OFF
  // Input is only held off while results are waiting at the output.
  a_stall_needs_output : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o)
    else $error("input stalled with no result pending");

  // After a word leaves the input register, a result is valid at the output next cycle.
  a_move_reaches_output : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && !skid_valid_q) |=> out_valid_o)
    else $error("processed word did not reach the output");

  // A valid result never enables work RAM writes while work RAM reads are disabled.
  a_wram_write_gated : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_word_o.wram_write_enable) |-> out_word_o.wram_read_enable)
    else $error("work RAM write enable without read enable");
`endif

endmodule
